/* hw/rtl/sgf_pkg.sv */
// ----------------------------------------------------------------------------
// sgf_pkg - shared types and constants for the scaled glyph framebuffer
// Request codes, controller states, and the command/status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package sgf_pkg;

	// Field widths of the request/response transactions
	localparam int COORD_W   = 8;
	localparam int GLYPH_W   = 35;
	localparam int SCALE_W   = 4;
	localparam int BADDR_W   = 10;
	localparam int DATA_W    = 8;

	// Glyph column stride in glyph_bits, and log2 of the rows per store page
	localparam int GLYPH_STRIDE = 7;
	localparam int PAGE_SHIFT   = 3;

	// Glyph bit index width (covers column/row indexes up to 8x8 with stride 7)
	localparam int SH_W  = 6;
	// Pixel byte index width: 255 + 31*256 and the store depth both fit
	localparam int IDX_W = 14;

	// Default geometry
	localparam int DEF_SCREEN_WIDTH  = 128;
	localparam int DEF_SCREEN_HEIGHT = 64;
	localparam int DEF_GLYPH_COLS    = 5;
	localparam int DEF_GLYPH_ROWS    = 7;
	localparam int DEF_STORE_BYTES   = 1024;

	typedef enum logic [1:0] {
		REQ_GLYPH = 2'd0,
		REQ_PIXEL = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_READ  = 2'd3
	} req_type_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_CELL,
		S_PRD,
		S_PWR,
		S_CLEAR,
		S_RADDR,
		S_DONE
	} sgf_state_t;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic adv_cell;
		logic adv_sq;
		logic pix_rd;
		logic pix_wr;
		logic rd_en;
		logic clr_we;
		logic res_load;
	} sgf_cmd_t;

	typedef struct packed {
		logic scale_zero;
		logic bit_set;
		logic last_cell;
		logic last_sq;
		logic clr_last;
		logic is_pixel;
		logic out_free;
	} sgf_sts_t;

endpackage

/* hw/rtl/sgf_req_if.sv */
// ----------------------------------------------------------------------------
// sgf_req_if - request channel
// Valid/ready channel carrying one framebuffer request per transaction.
// ----------------------------------------------------------------------------
interface sgf_req_if
	import sgf_pkg::*;
();
	logic                 valid;
	logic                 ready;
	req_type_t            req_type;
	logic [COORD_W-1:0]   x_pos;
	logic [COORD_W-1:0]   y_pos;
	logic [GLYPH_W-1:0]   glyph_bits;
	logic [SCALE_W-1:0]   scale;
	logic                 pixel_on;
	logic [BADDR_W-1:0]   byte_addr;

	modport source (
		output valid, req_type, x_pos, y_pos, glyph_bits, scale, pixel_on, byte_addr,
		input  ready
	);

	modport sink (
		input  valid, req_type, x_pos, y_pos, glyph_bits, scale, pixel_on, byte_addr,
		output ready
	);
endinterface

/* hw/rtl/sgf_rsp_if.sv */
// ----------------------------------------------------------------------------
// sgf_rsp_if - response channel
// Valid/ready channel carrying one read byte per transaction.
// ----------------------------------------------------------------------------
interface sgf_rsp_if
	import sgf_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] read_data;

	modport source (
		output valid, read_data,
		input  ready
	);

	modport sink (
		input  valid, read_data,
		output ready
	);
endinterface

/* hw/rtl/sgf_ctrl.sv */
// ----------------------------------------------------------------------------
// sgf_ctrl - request sequencer
// State machine that walks glyph cells and square pixels, runs clear sweeps
// and byte reads, and hands results to the output register.
// ----------------------------------------------------------------------------
module sgf_ctrl
	import sgf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  req_type_t in_type,
	input  sgf_sts_t  sts,
	output sgf_cmd_t  cmd
);

	sgf_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					unique case (in_type)
						REQ_GLYPH: state_d = S_CELL;
						REQ_PIXEL: state_d = S_PRD;
						REQ_CLEAR: state_d = S_CLEAR;
						REQ_READ:  state_d = S_RADDR;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_CELL: begin
				priority if (sts.scale_zero) state_d = S_DONE;
				else if (sts.bit_set)        state_d = S_PRD;
				else if (sts.last_cell)      state_d = S_DONE;
				else                         state_d = S_CELL;
			end
			S_PRD: state_d = S_PWR;
			S_PWR: begin
				priority if (sts.is_pixel)  state_d = S_DONE;
				else if (!sts.last_sq)      state_d = S_PRD;
				else if (sts.last_cell)     state_d = S_DONE;
				else                        state_d = S_CELL;
			end
			S_CLEAR: begin
				if (sts.clr_last) state_d = S_DONE;
			end
			S_RADDR: state_d = S_DONE;
			S_DONE: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	// Commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_INIT:  cmd.clr_we = 1'b1;
			S_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.load     = in_valid;
			end
			S_CELL: begin
				cmd.adv_cell = !sts.scale_zero && !sts.bit_set && !sts.last_cell;
			end
			S_PRD:   cmd.pix_rd = 1'b1;
			S_PWR: begin
				cmd.pix_wr   = 1'b1;
				cmd.adv_sq   = !sts.is_pixel && !sts.last_sq;
				cmd.adv_cell = !sts.is_pixel && sts.last_sq && !sts.last_cell;
			end
			S_CLEAR: cmd.clr_we = 1'b1;
			S_RADDR: cmd.rd_en  = 1'b1;
			S_DONE:  cmd.res_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

/* hw/rtl/sgf_dp.sv */
// ----------------------------------------------------------------------------
// sgf_dp - framebuffer datapath
// Request registers, glyph/square walk counters, pixel address decode,
// the byte store with one read and one write port, and the result register.
// ----------------------------------------------------------------------------
module sgf_dp
	import sgf_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
	parameter int GLYPH_COLS    = DEF_GLYPH_COLS,
	parameter int GLYPH_ROWS    = DEF_GLYPH_ROWS,
	parameter int STORE_BYTES   = DEF_STORE_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sgf_cmd_t           cmd,
	input  req_type_t          in_type,
	input  logic [COORD_W-1:0] in_x,
	input  logic [COORD_W-1:0] in_y,
	input  logic [GLYPH_W-1:0] in_glyph,
	input  logic [SCALE_W-1:0] in_scale,
	input  logic               in_on,
	input  logic [BADDR_W-1:0] in_baddr,
	input  logic               out_ready,
	output sgf_sts_t           sts,
	output logic               out_valid,
	output logic [DATA_W-1:0]  out_data
);

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int CW     = (GLYPH_COLS > 1) ? $clog2(GLYPH_COLS) : 1;
	localparam int RW     = (GLYPH_ROWS > 1) ? $clog2(GLYPH_ROWS) : 1;

	// Request registers
	req_type_t          type_q;
	logic [COORD_W-1:0] y0_q;
	logic [GLYPH_W-1:0] glyph_q;
	logic [SCALE_W-1:0] scale_q;
	logic               on_q;
	logic [BADDR_W-1:0] baddr_q;

	// Walk state
	logic [CW-1:0]      c_q;
	logic [RW-1:0]      r_q;
	logic [SCALE_W-1:0] dx_q, dy_q;
	logic [COORD_W-1:0] colbase_q, rowbase_q;
	logic [SH_W-1:0]    sh_q, colsh_q;

	// Store
	logic [DATA_W-1:0]  mem_q [STORE_BYTES];
	logic [DATA_W-1:0]  rdata_q;
	logic [ADDR_W-1:0]  clr_q;

	// Pixel pipeline
	logic [ADDR_W-1:0]  idx_s1;
	logic [DATA_W-1:0]  mask_s1;
	logic               ok_s1;

	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;

	logic [COORD_W-1:0] px, py;
	logic [IDX_W-1:0]   pix_idx;
	logic               pix_ok;
	logic [IDX_W-1:0]   baddr_ext;
	logic [ADDR_W-1:0]  rd_addr;
	logic [63:0]        glyph_ext;
	logic               dy_last, dx_last;

	// Pixel decode: page layout, byte x + (y/8)*width, bit y mod 8
	assign px        = colbase_q + COORD_W'(dx_q);
	assign py        = rowbase_q + COORD_W'(dy_q);
	assign pix_idx   = IDX_W'(px) + IDX_W'(py[COORD_W-1:PAGE_SHIFT]) * IDX_W'(SCREEN_WIDTH);
	assign pix_ok    = ({1'b0, px} < 9'(SCREEN_WIDTH)) && ({1'b0, py} < 9'(SCREEN_HEIGHT))
	                   && (pix_idx < IDX_W'(STORE_BYTES));
	assign baddr_ext = IDX_W'(baddr_q);
	assign rd_addr   = cmd.pix_rd ? pix_idx[ADDR_W-1:0] : baddr_ext[ADDR_W-1:0];
	assign glyph_ext = 64'(glyph_q);

	assign dy_last = (dy_q == scale_q - SCALE_W'(1));
	assign dx_last = (dx_q == scale_q - SCALE_W'(1));

	assign sts.scale_zero = (scale_q == '0);
	assign sts.bit_set    = glyph_ext[sh_q];
	assign sts.last_cell  = (c_q == CW'(GLYPH_COLS - 1)) && (r_q == RW'(GLYPH_ROWS - 1));
	assign sts.last_sq    = dx_last && dy_last;
	assign sts.clr_last   = (clr_q == ADDR_W'(STORE_BYTES - 1));
	assign sts.is_pixel   = (type_q == REQ_PIXEL);
	assign sts.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q    <= in_type;
			y0_q      <= in_y;
			glyph_q   <= in_glyph;
			scale_q   <= in_scale;
			on_q      <= (in_type == REQ_GLYPH) ? 1'b1 : in_on;
			baddr_q   <= in_baddr;
			c_q       <= '0;
			r_q       <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
			colbase_q <= in_x;
			rowbase_q <= in_y;
			sh_q      <= '0;
			colsh_q   <= '0;
		end else if (cmd.adv_cell) begin
			dx_q <= '0;
			dy_q <= '0;
			if (r_q == RW'(GLYPH_ROWS - 1)) begin
				r_q       <= '0;
				c_q       <= c_q + CW'(1);
				colbase_q <= colbase_q + COORD_W'(scale_q);
				rowbase_q <= y0_q;
				colsh_q   <= colsh_q + SH_W'(GLYPH_STRIDE);
				sh_q      <= colsh_q + SH_W'(GLYPH_STRIDE);
			end else begin
				r_q       <= r_q + RW'(1);
				rowbase_q <= rowbase_q + COORD_W'(scale_q);
				sh_q      <= sh_q + SH_W'(1);
			end
		end else if (cmd.adv_sq) begin
			if (dy_last) begin
				dy_q <= '0;
				dx_q <= dx_q + SCALE_W'(1);
			end else begin
				dy_q <= dy_q + SCALE_W'(1);
			end
		end
	end

	// Pixel read stage: capture address, mask and range check
	always_ff @(posedge clk) begin
		if (cmd.pix_rd) begin
			idx_s1  <= pix_idx[ADDR_W-1:0];
			mask_s1 <= DATA_W'(1) << py[PAGE_SHIFT-1:0];
			ok_s1   <= pix_ok;
		end
	end

	// Store ports
	always_ff @(posedge clk) begin
		if (cmd.pix_rd || cmd.rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_we) begin
			mem_q[clr_q] <= '0;
		end else if (cmd.pix_wr && ok_s1) begin
			mem_q[idx_s1] <= on_q ? (rdata_q | mask_s1) : (rdata_q & ~mask_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_q <= sts.clr_last ? '0 : clr_q + ADDR_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_data_q <= ((type_q == REQ_READ) && (baddr_ext < IDX_W'(STORE_BYTES)))
			              ? rdata_q : '0;
		end
	end

endmodule

/* hw/rtl/scaled_glyph_framebuffer_core.sv */
// Sequence: a pixel write reads its byte and then writes it back; a byte read
//   registers the store output; a clear sweeps every byte; a glyph walks every
//   cell and read-modify-writes each pixel of a lit cell's scale x scale square.
// Flow: one request at a time; the next is taken once the result is in the free output register.
// Reset: asynchronous, active low; afterwards a clearing pass over all
//   STORE_BYTES bytes zeroes the store while req.ready stays low.
// ----------------------------------------------------------------------------
// scaled_glyph_framebuffer_core - 1-bpp page-layout framebuffer top level
// Glyph blit with integer magnification, pixel write, store clear and
// byte readback behind valid/ready request and response channels.
// ----------------------------------------------------------------------------
module scaled_glyph_framebuffer_core
	import sgf_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
	parameter int GLYPH_COLS    = DEF_GLYPH_COLS,
	parameter int GLYPH_ROWS    = DEF_GLYPH_ROWS,
	parameter int STORE_BYTES   = DEF_STORE_BYTES
) (
	input logic       clk,
	input logic       arst_n,
	sgf_req_if.sink   req,
	sgf_rsp_if.source rsp
);

	// Controller <-> datapath bundles
	sgf_cmd_t cmd;
	sgf_sts_t sts;

	// Request transaction is accepted only in the controller's idle state
	assign req.ready = cmd.in_ready;

	// Sequencer: walks glyph cells, then each lit cell's scale x scale square
	// as read-modify-write pixel pairs; also drives clear sweeps and reads.
	sgf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_type  (req.req_type),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: store, counters, pixel decode and the response register.
	// The response register lets a new request start while the last
	// response transaction is still pending.
	sgf_dp #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT),
		.GLYPH_COLS    (GLYPH_COLS),
		.GLYPH_ROWS    (GLYPH_ROWS),
		.STORE_BYTES   (STORE_BYTES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_type   (req.req_type),
		.in_x      (req.x_pos),
		.in_y      (req.y_pos),
		.in_glyph  (req.glyph_bits),
		.in_scale  (req.scale),
		.in_on     (req.pixel_on),
		.in_baddr  (req.byte_addr),
		.out_ready (rsp.ready),
		.sts       (sts),
		.out_valid (rsp.valid),
		.out_data  (rsp.read_data)
	);

`ifndef SYNTHESIS
	// One request in flight: ready drops right after an accepted transaction
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("request accepted while another is in flight");

	// Store writes never overlap the idle/accept window
	a_no_write_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clr_we || cmd.pix_wr) |-> !req.ready)
		else $error("store write while accepting requests");

	// A result is loaded only into a free or draining response register
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!rsp.valid || rsp.ready))
		else $error("pending response overwritten");
`endif

endmodule
